/* rtl/text_console_writer_defines.svh */
// Assertion macros for the text console writer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define TCW_NEVER(lbl, clk, rst_n, cond, msg) \
    `TCW_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Used by the register block, controller, datapath and top level.
package tcw_pkg;

    // Default grid geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int IDX_W  = 11;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'd0;

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COLOR = '0;
    localparam logic [ATTR_W-1:0]    DEFAULT_COLOR_RESET = 8'd7;

    // Commands from controller to datapath
    typedef struct packed {
        logic hold_item;
        logic put_now;
        logic put_held;
        logic rd_item;
        logic load_read;
        logic scroll_start;
        logic copy_step;
        logic zero_step;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cursor_full;
        logic copy_last;
        logic zero_last;
    } status_t;

endpackage

/* rtl/tcw_regs.sv */
// Configuration register block on an APB-style port.
// Depends on tcw_pkg for address layout and reset values.
module tcw_regs import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ATTR_W-1:0]  default_color
);

    logic [ATTR_W-1:0]    default_color_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode the word index of the access
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Update the default colour on a completed write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
        end
        else if (wr_en && (reg_idx == REG_DEFAULT_COLOR))
        begin
            default_color_reg <= pwdata[ATTR_W-1:0];
        end
    end

    // Return register contents on read
    assign prdata = (reg_idx == REG_DEFAULT_COLOR) ? PDATA_W'(default_color_reg) : '0;

    assign default_color = default_color_reg;

endmodule

/* rtl/tcw_ctrl.sv */
// Controller state machine: handshakes, clearing pass and scroll sequencing.
// Uses tcw_pkg command and status structs and the assertion macros of the defines header.
`include "text_console_writer_defines.svh"
module tcw_ctrl import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    op,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // Take a word only when idle and the result slot is free this edge
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Sequence the work for each word
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.zero_step = 1'b1;
                if (status.zero_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.hold_item = 1'b1;
                    if (op == OP_READ)
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_READ;
                    end
                    else if (status.cursor_full)
                    begin
                        cmd.scroll_start = 1'b1;
                        state_next       = S_COPY;
                    end
                    else
                    begin
                        cmd.put_now    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.load_read  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (status.zero_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.put_held   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TCW_ASSERT(a_full_put_scrolls, clk, rst_n, accept && (op == OP_PUT) && status.cursor_full |=> state_reg == S_COPY, "put at end of screen did not start a scroll")
    `TCW_ASSERT(a_copy_then_zero, clk, rst_n, (state_reg == S_COPY) && status.copy_last |=> state_reg == S_ZERO, "row copy did not hand over to bottom row clear")
    `TCW_NEVER(a_read_slot_busy, clk, rst_n, (state_reg == S_READ) && out_valid_reg, "read result would overwrite a pending word")
    `TCW_NEVER(a_put_slot_busy, clk, rst_n, (state_reg == S_PUT) && out_valid_reg, "scrolled put would overwrite a pending word")

endmodule

/* rtl/tcw_dp.sv */
// Datapath: cell store, cursor tracking, scroll copy and result register.
// Depends on tcw_pkg for field widths, character codes and command structs.
module tcw_dp import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [CHAR_W-1:0] character,
    input  logic [ATTR_W-1:0] color,
    input  logic              use_default,
    input  logic [IDX_W-1:0]  cell_index,
    input  logic [ATTR_W-1:0] default_color,
    output logic [CHAR_W-1:0] cell_char,
    output logic [ATTR_W-1:0] cell_color,
    output logic [IDX_W-1:0]  cursor,
    output logic              scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CUR_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    logic [CELL_W-1:0] mem [CELLS];

    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CUR_W-1:0]  ptr_reg, ptr_next;
    logic [CELL_W-1:0] rdata_reg;
    logic              rd_inrange_reg;
    logic [CHAR_W-1:0] ch_hold_reg;
    logic [ATTR_W-1:0] attr_hold_reg;
    logic [CHAR_W-1:0] cell_char_reg;
    logic [ATTR_W-1:0] cell_color_reg;
    logic [IDX_W-1:0]  cursor_out_reg;
    logic              scrolled_reg;

    logic [CHAR_W-1:0] put_ch;
    logic [ATTR_W-1:0] put_attr;
    logic [ATTR_W-1:0] in_attr;
    logic              do_put;
    logic              is_nl;
    logic              col_last;
    logic [CUR_W-1:0]  put_cursor;
    logic [COL_W-1:0]  put_col;
    logic              idx_in_range;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Report cursor and sweep position
    assign status.cursor_full = (cursor_reg == CUR_W'(CELLS));
    assign status.copy_last   = (ptr_reg == CUR_W'(CELLS));
    assign status.zero_last   = (ptr_reg == CUR_W'(CELLS - 1));

    // Pick the character being put, live or held over a scroll
    assign in_attr  = use_default ? default_color : color;
    assign put_ch   = cmd.put_held ? ch_hold_reg : character;
    assign put_attr = cmd.put_held ? attr_hold_reg : in_attr;
    assign do_put   = cmd.put_now || cmd.put_held;
    assign is_nl    = (put_ch == NEWLINE_CHAR);
    assign col_last = (col_reg == COL_W'(COLUMNS - 1));

    // Advance the cursor: newline jumps to the next row start
    assign put_cursor = is_nl ? (cursor_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS))
                              : (cursor_reg + CUR_W'(1));
    assign put_col    = (is_nl || col_last) ? '0 : (col_reg + COL_W'(1));

    assign idx_in_range = (32'(cell_index) < CELLS);

    // Select the single write of this cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(ptr_reg);
        wr_data = '0;
        if (do_put && !is_nl)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cursor_reg);
            wr_data = {put_attr, put_ch};
        end
        else if (cmd.copy_step && (ptr_reg > CUR_W'(COLUMNS)))
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ptr_reg - CUR_W'(COLUMNS + 1));
            wr_data = rdata_reg;
        end
        else if (cmd.zero_step)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ptr_reg);
            wr_data = {{ATTR_W{1'b0}}, NULL_CHAR};
        end
    end

    // Select the single read of this cycle
    assign rd_en   = (cmd.rd_item && idx_in_range)
                     || (cmd.copy_step && (ptr_reg < CUR_W'(CELLS)));
    assign rd_addr = cmd.rd_item ? ADDR_W'(cell_index) : ADDR_W'(ptr_reg);

    // Cell store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Next cursor, column and sweep pointer
    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        ptr_next    = ptr_reg;
        if (cmd.scroll_start)
        begin
            cursor_next = CUR_W'(CELLS - COLUMNS);
            col_next    = '0;
            ptr_next    = CUR_W'(COLUMNS);
        end
        else if (do_put)
        begin
            cursor_next = put_cursor;
            col_next    = put_col;
        end
        if (cmd.copy_step)
        begin
            ptr_next = status.copy_last ? CUR_W'(CELLS - COLUMNS) : (ptr_reg + CUR_W'(1));
        end
        else if (cmd.zero_step)
        begin
            ptr_next = ptr_reg + CUR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            col_reg    <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            ptr_reg    <= ptr_next;
        end
    end

    // Hold the accepted word and load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.hold_item)
        begin
            ch_hold_reg   <= character;
            attr_hold_reg <= in_attr;
        end
        if (cmd.rd_item)
        begin
            rd_inrange_reg <= idx_in_range;
        end
        if (do_put)
        begin
            cell_char_reg  <= '0;
            cell_color_reg <= '0;
            cursor_out_reg <= IDX_W'(put_cursor);
            scrolled_reg   <= cmd.put_held;
        end
        else if (cmd.load_read)
        begin
            cell_char_reg  <= rd_inrange_reg ? rdata_reg[CHAR_W-1:0] : '0;
            cell_color_reg <= rd_inrange_reg ? rdata_reg[CELL_W-1:CHAR_W] : '0;
            cursor_out_reg <= IDX_W'(cursor_reg);
            scrolled_reg   <= 1'b0;
        end
    end

    assign cell_char  = cell_char_reg;
    assign cell_color = cell_color_reg;
    assign cursor     = cursor_out_reg;
    assign scrolled   = scrolled_reg;

endmodule

/* rtl/text_console_writer.sv */
// Text console writer: a put without scroll gives its result word in the cycle after
// acceptance and takes one item per cycle while result words are taken; a read passes
// the registered cell store read port and the READ state, taking no new item meanwhile.
// A put that finds the screen full copies the store row by row, one cell per cycle.
// After reset a clearing pass zeroes COLUMNS*ROWS cells, one per cycle (2000 at 80x25),
// while no item is accepted; configuration writes are taken throughout.
module text_console_writer import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [CHAR_W-1:0]  character,
    input  logic [ATTR_W-1:0]  color,
    input  logic               use_default,
    input  logic [IDX_W-1:0]   cell_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  cell_char,
    output logic [ATTR_W-1:0]  cell_color,
    output logic [IDX_W-1:0]   cursor,
    output logic               scrolled,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cmd_t              cmd;
    status_t           status;
    logic [ATTR_W-1:0] default_color;

    // Configuration registers
    tcw_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .default_color (default_color)
    );

    // Sequencing and handshakes
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Cell store and cursor
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .character     (character),
        .color         (color),
        .use_default   (use_default),
        .cell_index    (cell_index),
        .default_color (default_color),
        .cell_char     (cell_char),
        .cell_color    (cell_color),
        .cursor        (cursor),
        .scrolled      (scrolled)
    );

endmodule

/* sim/tb_top.sv */
// Self-checking bench for the text console writer: directed table, then randomised words.
// Depends on tcw_pkg and the text_console_writer RTL; reads no files.
module tb_top import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int PHASE_WORDS = 312;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam logic [PADDR_W-1:0] ADDR_DEFAULT_COLOR = {REG_DEFAULT_COLOR, 2'b00};

    // Idling per phase, in percent: none, sender only, receiver only, both
    localparam int SEND_IDLE_PCT [4]  = '{0, 56, 0, 21};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 56, 21};
    // Newline share of puts, rotated every 160 words
    localparam int NEWLINE_PCT [3] = '{20, 0, 6};

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] color;
        logic              use_default;
        logic [IDX_W-1:0]  cell_index;
    } console_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_color;
        logic [IDX_W-1:0]  cursor;
        logic              scrolled;
    } console_result_t;

    typedef struct packed {
        console_word_t   word;
        logic [5:0]      repeats;
        logic            typed;
        console_result_t want;
    } script_row_t;

    localparam int SCRIPT_LEN = 15;

    // Directed table; typed results only where they are plain to see
    script_row_t script [SCRIPT_LEN] = '{
        // cleared store after reset, then an out-of-range read with junk fields
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd0, 1'b0}},
        '{'{OP_READ, 8'hFF, 8'hFF, 1'b1, 11'd2047}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd0, 1'b0}},
        // own colour, then the null character with the default colour
        '{'{OP_PUT, 8'h41, 8'h1E, 1'b0, 11'd2047}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd1, 1'b0}},
        '{'{OP_PUT, NULL_CHAR, 8'hFF, 1'b1, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd2, 1'b0}},
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h41, 8'h1E, 11'd2, 1'b0}},
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd1}, 6'd1, 1'b1,
            '{8'h00, DEFAULT_COLOR_RESET, 11'd2, 1'b0}},
        '{'{OP_PUT, 8'hFF, 8'h00, 1'b0, 11'd1024}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd3, 1'b0}},
        // walk down to the start of the bottom row
        '{'{OP_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 11'd0}, 6'd24, 1'b0, '0},
        // newline on the bottom row leaves the cursor one past the end
        '{'{OP_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd2000, 1'b0}},
        // deferred scroll followed by another newline
        '{'{OP_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd2000, 1'b1}},
        '{'{OP_PUT, 8'h42, 8'h55, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd1921, 1'b1}},
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd1920}, 6'd1, 1'b1, '{8'h42, 8'h55, 11'd1921, 1'b0}},
        // top row now holds what was the third row: empty
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd0}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd1921, 1'b0}},
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd1999}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd1921, 1'b0}},
        '{'{OP_READ, 8'h00, 8'h00, 1'b0, 11'd2000}, 6'd1, 1'b1, '{8'h00, 8'h00, 11'd1921, 1'b0}}
    };

    // Block ports; the inputs are all known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = OP_PUT;
    logic [CHAR_W-1:0]  character = '0;
    logic [ATTR_W-1:0]  color = '0;
    logic               use_default = 1'b0;
    logic [IDX_W-1:0]   cell_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_color;
    logic [IDX_W-1:0]   cursor;
    logic               scrolled;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Typed expectation travelling with the word on the input channel
    logic               word_typed = 1'b0;
    console_result_t    typed_result = '0;

    // Predicted screen contents, cursor and default colour
    logic [CELL_W-1:0]  screen [CELLS];
    int unsigned        cursor_pos = 0;
    logic [ATTR_W-1:0]  screen_default = DEFAULT_COLOR_RESET;

    console_result_t    expected_results [$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 error_count = 0;
    int                 words_taken = 0;
    int                 reads_taken = 0;
    int                 results_seen = 0;
    int                 scroll_count = 0;
    int                 cycle_count = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .character   (character),
        .color       (color),
        .use_default (use_default),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_char   (cell_char),
        .cell_color  (cell_color),
        .cursor      (cursor),
        .scrolled    (scrolled),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Apply one word to the predicted console and return its result word
    function automatic console_result_t console_apply(console_word_t w);
        console_result_t r;
        logic [ATTR_W-1:0] attr;
        r = '0;
        if (w.op == OP_READ)
        begin
            if (w.cell_index < CELLS)
            begin
                r.cell_char  = screen[w.cell_index][CHAR_W-1:0];
                r.cell_color = screen[w.cell_index][CELL_W-1:CHAR_W];
            end
        end
        else
        begin
            // deferred scroll: shift rows up, blank the bottom row
            if (cursor_pos >= CELLS)
            begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                    screen[i] = screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    screen[i] = '0;
                cursor_pos = CELLS - COLUMNS;
                r.scrolled = 1'b1;
            end
            if (w.character == NEWLINE_CHAR)
                cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
            else
            begin
                attr = w.use_default ? screen_default : w.color;
                screen[cursor_pos] = {attr, w.character};
                cursor_pos++;
            end
        end
        r.cursor = cursor_pos[IDX_W-1:0];
        return r;
    endfunction

    // Random word; reads favour the bottom rows and sometimes fall off the end
    function automatic console_word_t random_word(int newline_pct);
        console_word_t w;
        int pick;
        w.op          = ($urandom_range(0, 99) < 40) ? OP_READ : OP_PUT;
        w.character   = CHAR_W'($urandom_range(0, 255));
        w.color       = ATTR_W'($urandom_range(0, 255));
        w.use_default = 1'($urandom_range(0, 1));
        w.cell_index  = IDX_W'($urandom_range(0, 2047));
        if (w.op == OP_PUT && $urandom_range(0, 99) < newline_pct)
            w.character = NEWLINE_CHAR;
        if (w.op == OP_READ)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                w.cell_index = IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
            else if (pick < 88)
                w.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
            else
                w.cell_index = IDX_W'($urandom_range(CELLS, 2047));
        end
        return w;
    endfunction

    // Present one word, idling first at random, and hold it until taken
    task automatic send_word(console_word_t w, logic typed, console_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= w.op;
        character    <= w.character;
        color        <= w.color;
        use_default  <= w.use_default;
        cell_index   <= w.cell_index;
        word_typed   <= typed;
        typed_result <= want;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Register write: setup then access phase
    task automatic write_default_color(logic [ATTR_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEFAULT_COLOR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        screen_default = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register read, compared with the predicted value
    task automatic check_default_color();
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEFAULT_COLOR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        if (got !== PDATA_W'(screen_default))
            report_mismatch("default_color readback", got, PDATA_W'(screen_default));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver stalls at the rate of the current phase
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check result words against the oldest expectation, then predict taken words
    always @(posedge clk)
    begin : result_check
        console_result_t got;
        console_result_t want;
        console_word_t   taken;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{cell_char, cell_color, cursor, scrolled};
                results_seen++;
                if (got.scrolled === 1'b1)
                    scroll_count++;
                if (expected_results.size() == 0)
                    report_mismatch("result word with none pending", 32'(got), 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.cell_char !== want.cell_char)
                        report_mismatch("cell_char", 32'(got.cell_char), 32'(want.cell_char));
                    if (got.cell_color !== want.cell_color)
                        report_mismatch("cell_color", 32'(got.cell_color),
                                        32'(want.cell_color));
                    if (got.cursor !== want.cursor)
                        report_mismatch("cursor", 32'(got.cursor), 32'(want.cursor));
                    if (got.scrolled !== want.scrolled)
                        report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
                end
            end
            if (in_valid && in_ready)
            begin
                taken = '{op, character, color, use_default, cell_index};
                want  = console_apply(taken);
                words_taken++;
                if (taken.op == OP_READ)
                    reads_taken++;
                expected_results.push_back(word_typed ? typed_result : want);
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[text_console_writer] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        console_result_t  none;
        logic [ATTR_W-1:0] setting;
        int               nl_pct;
        none = '0;

        // Hold reset from time zero, release on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register reset value, readable during the clearing pass
        check_default_color();

        // Directed table
        for (int r = 0; r < SCRIPT_LEN; r++)
            for (int k = 0; k < script[r].repeats; k++)
                send_word(script[r].word, script[r].typed && script[r].repeats == 1,
                          script[r].want);
        in_valid <= 1'b0;

        // Random phases, each under its own idling and default colour
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[p];
            recv_stall_pct = RECV_STALL_PCT[p];
            while (expected_results.size() != 0)
                @(posedge clk);
            case (p)
                0: setting = 8'hFF;
                1: setting = 8'h00;
                2: setting = ATTR_W'($urandom_range(1, 254));
                default: setting = 8'hA5;
            endcase
            write_default_color(setting);
            check_default_color();
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                nl_pct = NEWLINE_PCT[(k / 160) % 3];
                send_word(random_word(nl_pct), 1'b0, none);
            end
            in_valid <= 1'b0;
        end

        // Drain, then allow a full scroll's worth of cycles for strays
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (CELLS + 4) @(posedge clk);

        $display("Run covered %0d words taken (%0d reads) and %0d result words checked,",
                 words_taken, reads_taken, results_seen);
        $display("including %0d scrolls, under four idling patterns and four colour settings.",
                 scroll_count);
        if (error_count == 0)
            $display("[text_console_writer] OK");
        else
            $display("[text_console_writer] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_regs.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
sim/tb_top.sv
